// ===== rtl/core/pia_pkg.sv =====
// Shared codes, widths and cell control struct for the positional insert/delete array.
`timescale 1ns / 1ps
package pia_pkg;
	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 6;
	localparam int CNT_W     = 7;

	localparam logic [1:0] ACT_INSERT   = 2'd0;
	localparam logic [1:0] ACT_DELETE   = 2'd1;
	localparam logic [1:0] ACT_TRAVERSE = 2'd2;
	localparam logic [1:0] ACT_RSVD     = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [POS_W-1:0]       pos;
		logic [CNT_W-1:0]       count;
		logic [DATA_W-1:0]      value;
	} cell_ctl_t;
endpackage

// ===== rtl/core/pia_cell.sv =====
// One slot of the list: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps
module pia_cell import pia_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	input  logic [DATA_W-1:0] head,
	output logic [DATA_W-1:0] data
);
	localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

	logic [CNT_W-1:0]  pos_c;
	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_nxt;

	assign pos_c = CNT_W'(ctl.pos);
	assign data  = data_q;

	always_comb begin
		data_nxt = data_q;
		unique case (ctl.op)
			CELL_INS: begin
				// slot at pos takes the new value, later live slots move up
				if (IDX_C == pos_c) begin
					data_nxt = ctl.value;
				end else if (IDX_C > pos_c && IDX_C <= ctl.count) begin
					data_nxt = left;
				end
			end
			CELL_DEL: begin
				if (IDX_C >= pos_c && IDX_P1 < ctl.count) begin
					data_nxt = right;
				end
			end
			CELL_ROT: begin
				// rotate the live part of the row: last live slot takes the head
				if (IDX_P1 == ctl.count) begin
					data_nxt = head;
				end else if (IDX_P1 < ctl.count) begin
					data_nxt = right;
				end
			end
			default: data_nxt = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end
endmodule

// ===== rtl/core/positional_insert_delete_array.sv =====
// Top level: command decode, entry count, traverse sequencer and the row of cells.
//
// Usage
//   Command channel: drive action/position/value with start high; the item is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: each result shows on status/element/entry_count/last for
//   exactly one cycle with done high. The receiver cannot stall; it must take
//   every result on the cycle it appears.
// Results and throughput
//   Insert, delete and every error give one result the cycle after the item is
//   taken; busy stays low, so such items can be issued every cycle.
//   Traverse of N entries gives N results, one per entry from the head on; busy
//   is high from the item until the last result is registered, so the next item
//   is taken at the earliest on the edge ending the last result. The row rotates
//   its live slots once per emitted entry and is back in order after the last
//   one.
//   Action code 3 is dropped: no result, nothing changes.
// Reset
//   arst_n clears the count, the sequencer and the result strobe. Entry slots
//   are not cleared; only slots below the count are ever read.
`timescale 1ns / 1ps
module positional_insert_delete_array import pia_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               action,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] element,
	output logic [CNT_W-1:0]         entry_count,
	output logic                     last
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_TRAV = 2'b10
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     idx_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] element_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic              last_q;

	logic              acc;
	logic [CNT_W-1:0]  cnt_c;
	logic [CNT_W-1:0]  pos_c;
	logic              trav_last;
	logic [1:0]        cmd_status;
	logic              cmd_ok;
	logic              cmd_res;
	cell_ctl_t         ctl;
	logic [DATA_W-1:0] cell_data [DEPTH];

	assign busy  = (state_q == ST_TRAV);
	assign acc   = start && !busy;
	assign cnt_c = CNT_W'(count_q);
	assign pos_c = CNT_W'(position);
	assign trav_last = ((CW'(idx_q) + CW'(1)) == count_q);

	// command check: full/empty is reported before a bad position
	always_comb begin
		cmd_status = STAT_OK;
		cmd_res    = 1'b1;
		unique case (action)
			ACT_INSERT: begin
				if (cnt_c >= DEPTH_C)   cmd_status = STAT_FULL;
				else if (pos_c > cnt_c) cmd_status = STAT_RANGE;
			end
			ACT_DELETE: begin
				if (cnt_c == '0)         cmd_status = STAT_EMPTY;
				else if (pos_c >= cnt_c) cmd_status = STAT_RANGE;
			end
			ACT_TRAVERSE: begin
				if (cnt_c == '0) cmd_status = STAT_EMPTY;
			end
			default: cmd_res = 1'b0;
		endcase
		cmd_ok = acc && cmd_res && (cmd_status == STAT_OK);
	end

	always_comb begin
		ctl.pos   = position;
		ctl.count = cnt_c;
		ctl.value = value;
		ctl.op    = CELL_HOLD;
		if (busy) begin
			ctl.op = CELL_ROT;
		end else if (cmd_ok && action == ACT_INSERT) begin
			ctl.op = CELL_INS;
		end else if (cmd_ok && action == ACT_DELETE) begin
			ctl.op = CELL_DEL;
		end
	end

	// row of cells; cell 0 is the head of the list
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign right_d = cell_data[0];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		pia_cell #(.IDX(i)) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.left  (left_d),
			.right (right_d),
			.head  (cell_data[0]),
			.data  (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc && cmd_res) begin
						done_q <= 1'b1;
						if (cmd_ok && action == ACT_INSERT) count_q <= count_q + CW'(1);
						if (cmd_ok && action == ACT_DELETE) count_q <= count_q - CW'(1);
						if (cmd_ok && action == ACT_TRAVERSE) begin
							done_q  <= 1'b0;
							idx_q   <= '0;
							state_q <= ST_TRAV;
						end
					end
				end
				ST_TRAV: begin
					done_q <= 1'b1;
					idx_q  <= idx_q + IW'(1);
					if (trav_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (busy) begin
			status_q      <= STAT_OK;
			element_q     <= cell_data[0];
			entry_count_q <= cnt_c;
			last_q        <= trav_last;
		end else begin
			status_q  <= cmd_status;
			element_q <= '0;
			last_q    <= 1'b1;
			if (cmd_ok && action == ACT_INSERT)      entry_count_q <= cnt_c + CNT_W'(1);
			else if (cmd_ok && action == ACT_DELETE) entry_count_q <= cnt_c - CNT_W'(1);
			else                                     entry_count_q <= cnt_c;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign element     = element_q;
	assign entry_count = entry_count_q;
	assign last        = last_q;

	a_trav_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> count_q != '0)
		else $error("traverse running on empty list");

	a_trav_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(count_q))
		else $error("count changed during traverse");

	a_trav_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && trav_last) |=> (!busy && done && last))
		else $error("traverse did not end on last entry");

	a_rsvd_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && action == ACT_RSVD) |=> !done)
		else $error("result produced for unused action");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(count_q) <= DEPTH_C)
		else $error("count above depth");
endmodule
